// ===== hw/rtl/humidity_temp_frame_checker_core_defines.svh =====
// assertion macros for the humidity/temperature frame checker
// expects signals clk and rst_n in the scope of each use
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_CORE_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HTFC_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HTFC_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/htfc_pkg.sv =====
// shared types, constants and the crc-8 byte step for the frame checker
// no dependencies
package htfc_pkg;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CRC_ERR   = 2'd1,
    STAT_RANGE_ERR = 2'd2
  } status_t;

  localparam logic [7:0]  CRC_POLY_RESET = 8'h31;

  // fixed-point conversion constants
  localparam logic [14:0] TEMP_SCALE  = 15'd17572;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic signed [14:0] HUM_OFFSET  = 15'sd600;

  // range limits
  localparam logic signed [15:0] TEMP_LOW    = -16'sd4000;
  localparam logic signed [15:0] TEMP_HIGH   = 16'sd10000;
  localparam logic signed [14:0] HUM_LOW     = 15'sd0;
  localparam logic signed [14:0] HUM_HIGH    = 15'sd10000;
  localparam logic signed [17:0] TEMP_MARKER = -18'sd100000;

  // first stage to second stage
  typedef struct packed {
    logic              kind;        // 0 temperature, 1 humidity
    logic [7:0]        crc_hi;      // crc after the high byte
    logic [7:0]        raw_lsb;
    logic [7:0]        check_byte;
    logic signed [15:0] temp;       // converted temperature, hundredths
    logic signed [14:0] hum;        // converted humidity, hundredths
  } stage_t;

  typedef struct packed {
    status_t            status;
    logic signed [17:0] temperature;
    logic signed [14:0] humidity;
    logic               report_valid;
  } result_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                          input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/htfc_front.sv =====
// input register stage: crc over the high byte and both fixed-point conversions
// depends on htfc_pkg
module htfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [7:0]        raw_msb,
  input  logic [7:0]        raw_lsb,
  input  logic [7:0]        check_byte,
  input  logic [7:0]        poly,
  input  logic              s1_take,
  output logic              s1_valid,
  output htfc_pkg::stage_t  s1
);
  import htfc_pkg::*;

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  stage_t       s1_r;
  stage_t       s1_nxt;
  logic         in_fire;
  logic [15:0]  raw;
  logic [30:0]  temp_prod;
  logic [29:0]  hum_prod;

  assign in_ready = !s1_valid_r || s1_take;
  assign in_fire  = in_valid && in_ready;
  assign raw      = {raw_msb, raw_lsb};

  always_comb begin
    temp_prod         = 31'(raw) * 31'(TEMP_SCALE);
    hum_prod          = 30'(raw) * 30'(HUM_SCALE);
    s1_nxt.kind       = kind;
    s1_nxt.crc_hi     = crc_byte(8'h00, raw_msb, poly);
    s1_nxt.raw_lsb    = raw_lsb;
    s1_nxt.check_byte = check_byte;
    s1_nxt.temp       = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
    s1_nxt.hum        = $signed({1'b0, hum_prod[29:16]}) - HUM_OFFSET;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

// ===== hw/rtl/htfc_check.sv =====
// result stage: crc over the low byte, compare, range checks, stored temperature
// depends on htfc_pkg and humidity_temp_frame_checker_core_defines.svh
`include "humidity_temp_frame_checker_core_defines.svh"

module htfc_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  htfc_pkg::stage_t  s1,
  input  logic [7:0]        poly,
  output logic              s1_take,
  output logic              out_valid,
  input  logic              out_ready,
  output htfc_pkg::result_t res
);
  import htfc_pkg::*;

  logic               out_valid_r;
  logic               out_valid_nxt;
  result_t            res_r;
  result_t            res_nxt;
  logic signed [17:0] temp_r;
  logic signed [17:0] temp_nxt;
  logic [7:0]         crc_lo;
  logic               crc_ok;
  logic signed [15:0] temp_val;
  logic signed [14:0] hum_val;
  logic               temp_bad;
  logic               hum_bad;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    crc_lo   = crc_byte(s1.crc_hi, s1.raw_lsb, poly);
    crc_ok   = (crc_lo == s1.check_byte);
    temp_val = s1.temp;
    hum_val  = s1.hum;
    temp_bad = (temp_val > TEMP_HIGH) || (temp_val < TEMP_LOW);
    hum_bad  = (hum_val <= HUM_LOW) || (hum_val >= HUM_HIGH);
  end

  always_comb begin
    temp_nxt             = temp_r;
    res_nxt.status       = STAT_OK;
    res_nxt.humidity     = '0;
    res_nxt.report_valid = 1'b0;
    if (!crc_ok) begin
      res_nxt.status = STAT_CRC_ERR;
    end else if (!s1.kind) begin
      if (temp_bad) begin
        temp_nxt       = TEMP_MARKER;
        res_nxt.status = STAT_RANGE_ERR;
      end else begin
        temp_nxt = {{2{temp_val[15]}}, temp_val};
      end
    end else begin
      res_nxt.humidity = hum_val;
      if (hum_bad) begin
        res_nxt.status = STAT_RANGE_ERR;
      end else begin
        res_nxt.report_valid = 1'b1;
      end
    end
    res_nxt.temperature = temp_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      temp_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        temp_r <= temp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  `HTFC_CHK_NEXT(a_crc_err_keeps_temp, s1_take && !crc_ok, $stable(temp_r), "crc error changed temperature")
  `HTFC_CHK_NEXT(a_hum_keeps_temp, s1_take && crc_ok && s1.kind, $stable(temp_r), "humidity frame changed temperature")
  `HTFC_CHK_NEXT(a_temp_marker, s1_take && crc_ok && !s1.kind && temp_bad, temp_r == TEMP_MARKER, "range error did not store marker")
  `HTFC_CHK_NOW(a_report_ok, out_valid_r && res_r.report_valid, res_r.status == STAT_OK, "report flagged with error status")

endmodule

// ===== hw/rtl/humidity_temp_frame_checker_core.sv =====
// top level of the humidity/temperature frame checker: ports, packing, config register
// depends on htfc_pkg, htfc_front and htfc_check
//
// Each input transaction is one three-byte sensor read frame (high byte, low byte,
// check byte) tagged by in_tuser as a temperature (0) or humidity (1) frame. A
// crc-8 (init 0, msb first, polynomial from cfg_data, reset 0x31) over the two
// data bytes is compared with the check byte; a mismatch gives status 1 and
// leaves the stored temperature alone. A good temperature frame is converted to
// hundredths of a degree as ((17572*raw)>>16)-4685 and stored, or, outside
// -4000..10000, the marker -100000 is stored and status 2 reported. A good
// humidity frame becomes ((12500*raw)>>16)-600 hundredths of a percent; inside
// 1..9999 the result carries report_valid with the stored temperature, otherwise
// status 2. Exactly one result transaction per input transaction, in order.
// Throughput is one transaction per clock while out_tready is held high; each frame
// passes the input register stage (high-byte crc and the constant multiplies) and
// then the result register stage (low-byte crc, compare, range checks and the
// temperature store). Back-pressure on the result side stalls both stages; the
// input is still taken while a result waits as long as the input stage can move
// forward. Write cfg_data only while the block is idle.
module humidity_temp_frame_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  // input frames
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // raw_msb[7:0], raw_lsb[15:8], check_byte[23:16]
  input  logic        in_tuser,   // req_type[0]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], temperature_c100[19:2],
                                  // humidity_c100[34:20], zero pad[39:35]
  output logic        out_tuser,  // report_valid[0]
  // crc polynomial write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import htfc_pkg::*;

  logic [7:0] poly_r;
  logic       s1_valid;
  logic       s1_take;
  stage_t     s1;
  result_t    res;

  // the polynomial register takes a write every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= CRC_POLY_RESET;
    end else if (cfg_valid) begin
      poly_r <= cfg_data;
    end
  end

  // input register stage
  htfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .kind       (in_tuser),
    .raw_msb    (in_tdata[7:0]),
    .raw_lsb    (in_tdata[15:8]),
    .check_byte (in_tdata[23:16]),
    .poly       (poly_r),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  // result register stage, holds the stored temperature
  htfc_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .poly      (poly_r),
    .s1_take   (s1_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // pack the result fields, lowest first
  assign out_tdata = {5'b0, res.humidity, res.temperature, res.status};
  assign out_tuser = res.report_valid;

endmodule
